>>> rtl/dapp_pkg.sv
// dapp_pkg: shared constants, result struct and digit accumulate function
// for the delimited ascii packet parser; no dependencies
package dapp_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 32;
  localparam int unsigned COUNT_W = $clog2(MAX_PACKET_BYTES + 1);

  localparam logic [7:0] CH_START  = 8'h40;
  localparam logic [7:0] CH_END    = 8'h24;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] PH_ID    = 2'd0;
  localparam logic [1:0] PH_INDEX = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam logic [31:0] CAP_ID      = 32'd65535;
  localparam logic [31:0] CAP_IDX_POS = 32'd32767;
  localparam logic [31:0] CAP_IDX_NEG = 32'd32768;
  localparam logic [31:0] CAP_VAL_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] CAP_VAL_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [15:0]        sim_id;
    logic signed [15:0] item_index;
    logic signed [31:0] item_value;
    logic               value_present;
  } res_t;

  // acc * 10 + digit, saturated at cap
  function automatic logic [31:0] push_digit(input logic [31:0] acc,
                                             input logic [3:0]  digit,
                                             input logic [31:0] cap);
    logic [35:0] n;
    n = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, digit};
    return (n > {4'b0, cap}) ? cap : n[31:0];
  endfunction

endpackage

>>> rtl/dapp_parse.sv
// dapp_parse: framing state and field accumulators, one byte per enable
// depends on dapp_pkg
module dapp_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [7:0]    data_byte,
  output logic          res_strobe,
  output dapp_pkg::res_t res
);
  import dapp_pkg::*;

  logic               capturing, capturing_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [1:0]         field_phase, field_phase_next;
  logic [15:0]        id_accum, id_accum_next;
  logic [15:0]        index_accum, index_accum_next;
  logic [31:0]        value_accum, value_accum_next;
  logic [1:0]         sign_flags, sign_flags_next;
  logic [2:0]         digits_stopped, digits_stopped_next;
  logic               equals_seen, equals_seen_next;
  logic               field_started, field_started_next;

  logic [2:0]  stop_bit;
  logic        is_digit;
  logic [3:0]  digit;
  logic [31:0] id_push, idx_push, val_push;

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit    = data_byte[3:0];
  assign stop_bit = 3'b001 << field_phase;
  assign id_push  = push_digit({16'b0, id_accum}, digit, CAP_ID);
  assign idx_push = push_digit({16'b0, index_accum}, digit,
                               sign_flags[0] ? CAP_IDX_NEG : CAP_IDX_POS);
  assign val_push = push_digit(value_accum, digit,
                               sign_flags[1] ? CAP_VAL_NEG : CAP_VAL_POS);

  always_comb begin
    capturing_next      = capturing;
    byte_count_next     = byte_count;
    field_phase_next    = field_phase;
    id_accum_next       = id_accum;
    index_accum_next    = index_accum;
    value_accum_next    = value_accum;
    sign_flags_next     = sign_flags;
    digits_stopped_next = digits_stopped;
    equals_seen_next    = equals_seen;
    field_started_next  = field_started;
    res_strobe          = 1'b0;

    res.sim_id        = id_accum;
    res.item_index    = sign_flags[0] ? -$signed(index_accum) : $signed(index_accum);
    res.item_value    = sign_flags[1] ? -$signed(value_accum) : $signed(value_accum);
    res.value_present = equals_seen;

    if (data_byte == CH_START) begin
      capturing_next      = 1'b1;
      byte_count_next     = COUNT_W'(1);
      field_phase_next    = PH_ID;
      id_accum_next       = '0;
      index_accum_next    = '0;
      value_accum_next    = '0;
      sign_flags_next     = '0;
      digits_stopped_next = '0;
      equals_seen_next    = 1'b0;
      field_started_next  = 1'b0;
    end else if (capturing) begin
      if (byte_count >= COUNT_W'(MAX_PACKET_BYTES)) begin
        capturing_next = 1'b0;
      end else begin
        byte_count_next = byte_count + COUNT_W'(1);
        if (data_byte == CH_END) begin
          res_strobe     = 1'b1;
          capturing_next = 1'b0;
        end else if (data_byte == CH_SLASH && field_phase == PH_ID) begin
          field_phase_next   = PH_INDEX;
          field_started_next = 1'b0;
        end else if (data_byte == CH_EQUALS && field_phase == PH_INDEX) begin
          field_phase_next   = PH_VALUE;
          equals_seen_next   = 1'b1;
          field_started_next = 1'b0;
        end else if ((digits_stopped & stop_bit) == 3'b000) begin
          if (data_byte == CH_MINUS && !field_started && field_phase != PH_ID) begin
            if (field_phase == PH_INDEX) begin
              sign_flags_next[0] = 1'b1;
            end else begin
              sign_flags_next[1] = 1'b1;
            end
            field_started_next = 1'b1;
          end else if (is_digit) begin
            field_started_next = 1'b1;
            if (field_phase == PH_ID) begin
              id_accum_next = id_push[15:0];
            end else if (field_phase == PH_INDEX) begin
              index_accum_next = idx_push[15:0];
            end else begin
              value_accum_next = val_push;
            end
          end else begin
            digits_stopped_next = digits_stopped | stop_bit;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing      <= 1'b0;
      byte_count     <= '0;
      field_phase    <= PH_ID;
      id_accum       <= '0;
      index_accum    <= '0;
      value_accum    <= '0;
      sign_flags     <= '0;
      digits_stopped <= '0;
      equals_seen    <= 1'b0;
      field_started  <= 1'b0;
    end else if (en) begin
      capturing      <= capturing_next;
      byte_count     <= byte_count_next;
      field_phase    <= field_phase_next;
      id_accum       <= id_accum_next;
      index_accum    <= index_accum_next;
      value_accum    <= value_accum_next;
      sign_flags     <= sign_flags_next;
      digits_stopped <= digits_stopped_next;
      equals_seen    <= equals_seen_next;
      field_started  <= field_started_next;
    end
  end

endmodule

>>> rtl/dapp_out_reg.sv
// dapp_out_reg: result register with valid/ready handshake
// depends on dapp_pkg
module dapp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  dapp_pkg::res_t      res,
  output logic                free,
  input  logic                result_ready,
  output logic                result_valid,
  output logic [15:0]         sim_id,
  output logic signed [15:0]  item_index,
  output logic signed [31:0]  item_value,
  output logic                value_present
);
  import dapp_pkg::*;

  res_t held;

  assign free          = !result_valid || result_ready;
  assign sim_id        = held.sim_id;
  assign item_index    = held.item_index;
  assign item_value    = held.item_value;
  assign value_present = held.value_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (load) begin
      held <= res;
    end
  end

endmodule

>>> rtl/delimited_ascii_packet_parser_top.sv
// delimited_ascii_packet_parser_top: input byte register, parser, result register
// depends on dapp_pkg, dapp_parse, dapp_out_reg
//
// usage
//   input channel: byte_valid / byte_ready with data_byte, one ascii byte per item
//   output channel: result_valid / result_ready with sim_id, item_index,
//   item_value and value_present, one item per completed '@' id '/' index
//   '=' value '$' packet
//   a byte is taken into an input register, then parsed, when the result
//   register can take data, by a compare and multiply-by-ten accumulate
//   that updates the framing state and, on '$', loads the result register
//   a '$' passes the input register, then the result register, to the outputs
//   throughput: one byte per cycle while the result register can take data
//   stall: when a result is held and result_ready is low the parser stops,
//   the input register fills and byte_ready drops; bytes are never lost
//   reset: synchronous, clears both registers' valid flags and sets the
//   parser idle, waiting for '@'
module delimited_ascii_packet_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic [7:0]         data_byte,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [15:0]        sim_id,
  output logic signed [15:0] item_index,
  output logic signed [31:0] item_value,
  output logic               value_present
);
  import dapp_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       en;
  logic       res_strobe;
  res_t       res;

  assign en         = in_full && advance;
  assign byte_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (byte_valid && byte_ready) begin
      in_byte <= data_byte;
    end
  end

  dapp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .data_byte  (in_byte),
    .res_strobe (res_strobe),
    .res        (res)
  );

  dapp_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (en && res_strobe),
    .res           (res),
    .free          (advance),
    .result_ready  (result_ready),
    .result_valid  (result_valid),
    .sim_id        (sim_id),
    .item_index    (item_index),
    .item_value    (item_value),
    .value_present (value_present)
  );

endmodule
